>>> hdl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Field widths and codes shared by the timer bank, its channels and its testbench.
// ----------------------------------------------------------------------------
package stb_pkg;

    // Fixed field widths of the command and result items
    localparam int CMD_W     = 3;
    localparam int SLOT_ID_W = 4;
    localparam int TIME_IN_W = 32;
    localparam int STATUS_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd5;

    // Reply status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

endpackage

>>> hdl/stb_if.sv
// ----------------------------------------------------------------------------
// stb_if
// Valid/ready channels of the timer bank: command items in, result items out.
// ----------------------------------------------------------------------------
interface stb_req_if;
    import stb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [SLOT_ID_W-1:0] slot;
    logic [TIME_IN_W-1:0] duration;
    logic                 start_now;
    logic                 repeat_mode;
    logic [TIME_IN_W-1:0] tick_delta;

    modport source
    (
        output valid, cmd, slot, duration, start_now, repeat_mode, tick_delta,
        input  ready
    );

    modport sink
    (
        input  valid, cmd, slot, duration, start_now, repeat_mode, tick_delta,
        output ready
    );
endinterface

interface stb_rsp_if;
    import stb_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [STATUS_W-1:0]  status;
    logic                 last;

    modport source
    (
        output valid, kind, slot_id, status, last,
        input  ready
    );

    modport sink
    (
        input  valid, kind, slot_id, status, last,
        output ready
    );
endinterface

>>> hdl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/stb_tick_alu.sv
// ----------------------------------------------------------------------------
// stb_tick_alu
// Shared elapsed-time unit: saturating add of the tick time, compare to period.
// ----------------------------------------------------------------------------
module stb_tick_alu #(
    parameter int W = 32
) (
    input  logic [W-1:0] elapsed,
    input  logic [W-1:0] dt,
    input  logic [W-1:0] period,
    output logic [W-1:0] sat_sum,
    output logic         reached
);

    logic [W:0] raw_sum;

    // Add with carry out, clamp on overflow
    assign raw_sum = {1'b0, elapsed} + {1'b0, dt};
    assign sat_sum = raw_sum[W] ? {W{1'b1}} : raw_sum[W-1:0];

    // Expiry compare
    assign reached = (sat_sum >= period);

endmodule

>>> hdl/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of one-shot / periodic timer slots walked by a slot-serial sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-----------------------------------------------
//  req     | in  | valid/ready  | cmd, slot, duration, start_now, repeat_mode,
//          |     |              | tick_delta
//  rsp     | out | valid/ready  | kind, slot_id, status, last
//
//  Tick: one slot per cycle through the shared add/compare unit unless a firing slot
//  finds the result register full; period and elapsed read from RAM one slot ahead.
//  Create: scans slots upward for the first free one.
//  req.ready is high only while idle; a full result register holds a firing slot.
//  Reset clears all slot flags at once; period and elapsed RAMs need no clearing.
// ----------------------------------------------------------------------------
module software_timer_bank #(
    parameter int NUM_SLOTS  = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    stb_req_if.sink         req,
    stb_rsp_if.source       rsp
);
    import stb_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TGT_CW = ((SLOT_W > SLOT_ID_W) ? SLOT_W : SLOT_ID_W) + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TICK = 3'd1;
    localparam logic [2:0] S_DONE = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_CMD  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;

    // Latched command item
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [SLOT_ID_W-1:0]  tgt_reg, tgt_next;
    logic [TIME_WIDTH-1:0] dur_reg, dur_next;
    logic [TIME_WIDTH-1:0] dt_reg, dt_next;
    logic                  start_reg, start_next;
    logic                  rep_reg, rep_next;

    // Slot flags
    logic [NUM_SLOTS-1:0]  used_reg, used_next;
    logic [NUM_SLOTS-1:0]  paused_reg, paused_next;
    logic [NUM_SLOTS-1:0]  repeat_reg, repeat_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg, out_kind_next;
    logic [SLOT_ID_W-1:0]  out_slot_reg, out_slot_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    // RAM ports
    logic                  el_we;
    logic [SLOT_W-1:0]     el_waddr;
    logic [TIME_WIDTH-1:0] el_wdata;
    logic                  pd_we;
    logic [SLOT_W-1:0]     raddr;
    logic [TIME_WIDTH-1:0] el_rdata;
    logic [TIME_WIDTH-1:0] pd_rdata;

    // Shared unit
    logic [TIME_WIDTH-1:0] alu_sum;
    logic                  alu_reached;

    // Helpers
    logic                  out_free;
    logic                  last_slot;
    logic                  tgt_ok;
    logic [SLOT_W-1:0]     tgt_idx;
    logic                  tgt_live;
    logic                  run;
    logic                  fire;
    logic                  proceed;
    logic [SLOT_W-1:0]     idx_inc;

    stb_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_elapsed_ram (
        .clk   (clk),
        .we    (el_we),
        .waddr (el_waddr),
        .wdata (el_wdata),
        .raddr (raddr),
        .rdata (el_rdata)
    );

    stb_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_period_ram (
        .clk   (clk),
        .we    (pd_we),
        .waddr (idx_reg),
        .wdata (dur_reg),
        .raddr (raddr),
        .rdata (pd_rdata)
    );

    stb_tick_alu #(
        .W (TIME_WIDTH)
    ) u_alu (
        .elapsed (el_rdata),
        .dt      (dt_reg),
        .period  (pd_rdata),
        .sat_sum (alu_sum),
        .reached (alu_reached)
    );

    // Common decode
    assign out_free  = !out_valid_reg || rsp.ready;
    assign last_slot = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign idx_inc   = last_slot ? '0 : idx_reg + SLOT_W'(1);
    assign tgt_ok    = (TGT_CW'(tgt_reg) < TGT_CW'(NUM_SLOTS));
    assign tgt_idx   = SLOT_W'(tgt_reg);
    assign tgt_live  = tgt_ok && used_reg[tgt_idx];
    assign run       = used_reg[idx_reg] && !paused_reg[idx_reg];
    assign fire      = (state_reg == S_TICK) && run && alu_reached;
    assign proceed   = !fire || out_free;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        tgt_next        = tgt_reg;
        dur_next        = dur_reg;
        dt_next         = dt_reg;
        start_next      = start_reg;
        rep_next        = rep_reg;
        used_next       = used_reg;
        paused_next     = paused_reg;
        repeat_next     = repeat_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        el_we           = 1'b0;
        el_waddr        = idx_reg;
        el_wdata        = '0;
        pd_we           = 1'b0;
        raddr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    tgt_next   = req.slot;
                    dur_next   = TIME_WIDTH'(req.duration);
                    dt_next    = TIME_WIDTH'(req.tick_delta);
                    start_next = req.start_now;
                    rep_next   = req.repeat_mode;
                    idx_next   = '0;
                    case (req.cmd)
                        CMD_TICK:   state_next = S_TICK;
                        CMD_CREATE: state_next = S_FIND;
                        default:    state_next = S_CMD;
                    endcase
                end
            end

            // One slot per cycle unless a fire stalls; next slot read on retiring
            S_TICK:
            begin
                raddr = proceed ? idx_inc : idx_reg;
                if (proceed)
                begin
                    if (run)
                    begin
                        el_we    = 1'b1;
                        el_wdata = (fire && repeat_reg[idx_reg]) ? '0 : alu_sum;
                    end
                    if (fire)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_FIRE;
                        out_slot_next   = SLOT_ID_W'(idx_reg);
                        out_status_next = ST_OK;
                        out_last_next   = 1'b0;
                        if (!repeat_reg[idx_reg])
                        begin
                            used_next[idx_reg]   = 1'b0;
                            paused_next[idx_reg] = 1'b0;
                            repeat_next[idx_reg] = 1'b0;
                        end
                    end
                    if (last_slot)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            // Closing reply of a tick
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REPLY;
                    out_slot_next   = '0;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // Scan upward for the lowest free slot
            S_FIND:
            begin
                if (!used_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        used_next[idx_reg]   = 1'b1;
                        paused_next[idx_reg] = !start_reg;
                        repeat_next[idx_reg] = rep_reg;
                        pd_we                = 1'b1;
                        el_we                = 1'b1;
                        out_valid_next       = 1'b1;
                        out_kind_next        = KIND_REPLY;
                        out_slot_next        = SLOT_ID_W'(idx_reg);
                        out_status_next      = ST_OK;
                        out_last_next        = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
                else if (last_slot)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_REPLY;
                        out_slot_next   = '0;
                        out_status_next = ST_FULL;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            // Single-slot commands
            S_CMD:
            begin
                el_waddr = tgt_idx;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REPLY;
                    out_slot_next   = tgt_reg;
                    out_status_next = tgt_live ? ST_OK : ST_EMPTY;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                    case (cmd_reg)
                        CMD_START:
                        begin
                            if (tgt_live)
                            begin
                                paused_next[tgt_idx] = 1'b0;
                            end
                        end
                        CMD_PAUSE:
                        begin
                            if (tgt_live)
                            begin
                                paused_next[tgt_idx] = 1'b1;
                            end
                        end
                        CMD_RESTART:
                        begin
                            if (tgt_live)
                            begin
                                paused_next[tgt_idx] = 1'b0;
                                el_we                = 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (tgt_live)
                            begin
                                used_next[tgt_idx]   = 1'b0;
                                paused_next[tgt_idx] = 1'b0;
                                repeat_next[tgt_idx] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // unknown command: plain ok reply
                            out_slot_next   = '0;
                            out_status_next = ST_OK;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            paused_reg    <= '0;
            repeat_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            used_reg      <= used_next;
            paused_reg    <= paused_next;
            repeat_reg    <= repeat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        tgt_reg        <= tgt_next;
        dur_reg        <= dur_next;
        dt_reg         <= dt_next;
        start_reg      <= start_next;
        rep_reg        <= rep_next;
        out_kind_reg   <= out_kind_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Ports
    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.kind    = out_kind_reg;
    assign rsp.slot_id = out_slot_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.last    = out_last_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("command accepted while a previous one was in flight");

    a_fire_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == KIND_FIRE) |-> (rsp.status == ST_OK && !rsp.last))
        else $error("fire event with reply fields set");

    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK || state_reg == S_FIND) |-> (int'(idx_reg) < NUM_SLOTS))
        else $error("slot walk index out of range");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!el_we && !pd_we))
        else $error("slot RAM written while idle");

endmodule

>>> sim/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// Watches both channels of the timer bank, predicts every result item and
// compares it.
// Each accepted command item updates a private copy of the slot table and
// queues the result items it must cause. Each accepted result item is checked
// field by field against the oldest queued item.
// ----------------------------------------------------------------------------
module stb_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic clk,
    input  logic rst_n,
    stb_req_if   req,
    stb_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   results_seen,
    output int   fires_seen
);
    import stb_pkg::*;

    typedef struct packed {
        logic                 kind;
        logic [SLOT_ID_W-1:0] slot_id;
        logic [STATUS_W-1:0]  status;
        logic                 last;
    } timer_result_t;

    // Private copy of the slot table
    logic                 timer_live     [NUM_SLOTS];
    logic                 timer_held     [NUM_SLOTS];
    logic                 timer_periodic [NUM_SLOTS];
    logic [TIME_IN_W-1:0] timer_period   [NUM_SLOTS];
    logic [TIME_IN_W-1:0] timer_elapsed  [NUM_SLOTS];

    timer_result_t expected_results[$];

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%t: %s", $time, what);
    endtask

    task automatic queue_result(input logic k, input logic [SLOT_ID_W-1:0] id,
                                input logic [STATUS_W-1:0] st, input logic fin);
        expected_results.push_back('{k, id, st, fin});
    endtask

    // Apply one command to the slot table and queue the result items it causes
    task automatic apply_command(input logic [CMD_W-1:0]     op,
                                 input logic [SLOT_ID_W-1:0] target,
                                 input logic [TIME_IN_W-1:0] dur,
                                 input logic                 run,
                                 input logic                 periodic,
                                 input logic [TIME_IN_W-1:0] dt);
        logic [TIME_IN_W:0] sum;
        bit                 found;
        found = 1'b0;
        case (op)
            CMD_TICK:
            begin
                // walk running slots upward, saturating the elapsed count
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (timer_live[s] && !timer_held[s])
                    begin
                        sum = {1'b0, timer_elapsed[s]} + {1'b0, dt};
                        timer_elapsed[s] = sum[TIME_IN_W] ? '1 : sum[TIME_IN_W-1:0];
                        if (timer_elapsed[s] >= timer_period[s])
                        begin
                            queue_result(KIND_FIRE, SLOT_ID_W'(s), ST_OK, 1'b0);
                            if (timer_periodic[s])
                            begin
                                timer_elapsed[s] = '0;
                            end
                            else
                            begin
                                timer_live[s]     = 1'b0;
                                timer_held[s]     = 1'b0;
                                timer_periodic[s] = 1'b0;
                            end
                        end
                    end
                end
                queue_result(KIND_REPLY, '0, ST_OK, 1'b1);
            end
            CMD_CREATE:
            begin
                // lowest free slot wins
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (!found && !timer_live[s])
                    begin
                        found             = 1'b1;
                        timer_live[s]     = 1'b1;
                        timer_held[s]     = !run;
                        timer_periodic[s] = periodic;
                        timer_period[s]   = dur;
                        timer_elapsed[s]  = '0;
                        queue_result(KIND_REPLY, SLOT_ID_W'(s), ST_OK, 1'b1);
                    end
                end
                if (!found)
                    queue_result(KIND_REPLY, '0, ST_FULL, 1'b1);
            end
            CMD_START, CMD_PAUSE, CMD_RESTART, CMD_REMOVE:
            begin
                if (target >= NUM_SLOTS || !timer_live[target])
                begin
                    queue_result(KIND_REPLY, target, ST_EMPTY, 1'b1);
                end
                else
                begin
                    case (op)
                        CMD_START:
                            timer_held[target] = 1'b0;
                        CMD_PAUSE:
                            timer_held[target] = 1'b1;
                        CMD_RESTART:
                        begin
                            timer_held[target]    = 1'b0;
                            timer_elapsed[target] = '0;
                        end
                        default:
                        begin
                            timer_live[target]     = 1'b0;
                            timer_held[target]     = 1'b0;
                            timer_periodic[target] = 1'b0;
                        end
                    endcase
                    queue_result(KIND_REPLY, target, ST_OK, 1'b1);
                end
            end
            default:
                // undefined codes are answered and otherwise ignored
                queue_result(KIND_REPLY, '0, ST_OK, 1'b1);
        endcase
    endtask

    // Compare one accepted result item with the oldest expectation
    task automatic check_result();
        timer_result_t want;
        results_seen++;
        if (rsp.kind === KIND_FIRE)
            fires_seen++;
        if (expected_results.size() == 0)
        begin
            log_failure($sformatf("unexpected result: kind %0d slot %0d status %0d last %0d",
                                  rsp.kind, rsp.slot_id, rsp.status, rsp.last));
        end
        else
        begin
            want = expected_results.pop_front();
            if (rsp.kind !== want.kind || rsp.slot_id !== want.slot_id ||
                rsp.status !== want.status || rsp.last !== want.last)
                log_failure($sformatf({"result %0d mismatch: expected kind %0d slot %0d ",
                                       "status %0d last %0d, got kind %0d slot %0d ",
                                       "status %0d last %0d"},
                                      results_seen, want.kind, want.slot_id, want.status,
                                      want.last, rsp.kind, rsp.slot_id, rsp.status,
                                      rsp.last));
        end
    endtask

    // Results are checked before the command of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                timer_live[s]     = 1'b0;
                timer_held[s]     = 1'b0;
                timer_periodic[s] = 1'b0;
                timer_period[s]   = '0;
                timer_elapsed[s]  = '0;
            end
            expected_results.delete();
            fail_count   = 0;
            results_seen = 0;
            fires_seen   = 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_result();
            if (req.valid === 1'b1 && req.ready === 1'b1)
                apply_command(req.cmd, req.slot, req.duration, req.start_now,
                              req.repeat_mode, req.tick_delta);
        end
        outstanding = expected_results.size();
    end

endmodule

>>> sim/software_timer_bank_tb.sv
// ----------------------------------------------------------------------------
// software_timer_bank_tb
// Stimulus and verdict for the timer bank.
// A directed opening covers empty targets, undefined codes, zero and maximum
// periods, pausing, restarting and elapsed saturation; random phases then mix
// creates, ticks and slot commands with bursty sending and a stalling
// receiver. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module software_timer_bank_tb;
    import stb_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 250;

    // Codes outside the defined command set
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    logic clk;
    logic rst_n;

    int fail_count;
    int outstanding;
    int results_seen;
    int fires_seen;

    int items_sent   = 0;
    int ticks_sent   = 0;
    int creates_sent = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;
    bit hold_request = 1'b0;

    stb_req_if req();
    stb_rsp_if rsp();

    software_timer_bank #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (32)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    stb_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .fires_seen   (fires_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk)
    begin
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: stall patterns in stretches, plus a long hold-off on request
    initial
    begin : receiver
        int mode;
        int stretch;
        int hold_left;
        rsp.ready = 1'b0;
        mode      = 0;
        stretch   = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(16, 96);
                end
                stretch--;
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= 1'($urandom_range(0, 1));
                    2:       rsp.ready <= ($urandom_range(0, 4) != 0);
                    default: rsp.ready <= ~rsp.ready;
                endcase
            end
        end
    end

    // Sender pacing: bursts of random length with random gaps
    task automatic pace_sender();
        int gap;
        if (steady)
            return;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Offer one command item at a falling edge and hold it until accepted
    task automatic send_item(input logic [CMD_W-1:0]     op,
                             input logic [SLOT_ID_W-1:0] target,
                             input logic [TIME_IN_W-1:0] dur,
                             input logic                 run,
                             input logic                 periodic,
                             input logic [TIME_IN_W-1:0] dt);
        req.valid       <= 1'b1;
        req.cmd         <= op;
        req.slot        <= target;
        req.duration    <= dur;
        req.start_now   <= run;
        req.repeat_mode <= periodic;
        req.tick_delta  <= dt;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        if (op == CMD_TICK)
            ticks_sent++;
        if (op == CMD_CREATE)
            creates_sent++;
        @(negedge clk);
        pace_sender();
    endtask

    // Time values weighted toward small numbers so that slots fire often
    function automatic logic [TIME_IN_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return TIME_IN_W'($urandom_range(0, 15));
            5, 6:          return TIME_IN_W'($urandom_range(0, 500));
            7:             return TIME_IN_W'($urandom);
            8:             return '1;
            default:       return 32'hFFFF_FF00 | TIME_IN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_phase(input int count, input int create_pct,
                                     input int tick_pct);
        int                   roll;
        logic [CMD_W-1:0]     op;
        logic [SLOT_ID_W-1:0] target;
        repeat (count)
        begin
            roll   = $urandom_range(0, 99);
            // low slots are the ones most often in use
            target = ($urandom_range(0, 3) != 0) ? SLOT_ID_W'($urandom_range(0, 7))
                                                 : SLOT_ID_W'($urandom_range(0, 15));
            if (roll < create_pct)
                op = CMD_CREATE;
            else if (roll < create_pct + tick_pct)
                op = CMD_TICK;
            else if (roll < 97)
            begin
                case ($urandom_range(0, 3))
                    0:       op = CMD_START;
                    1:       op = CMD_PAUSE;
                    2:       op = CMD_RESTART;
                    default: op = CMD_REMOVE;
                endcase
            end
            else
                op = ($urandom_range(0, 1) != 0) ? CMD_UNDEF_LO : CMD_UNDEF_HI;
            send_item(op, target, pick_time(), 1'($urandom_range(0, 3) != 0),
                      1'($urandom_range(0, 1)), pick_time());
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Main stimulus
    initial
    begin
        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.cmd         = CMD_TICK;
        req.slot        = '0;
        req.duration    = '0;
        req.start_now   = 1'b0;
        req.repeat_mode = 1'b0;
        req.tick_delta  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty bank: tick alone, slot commands on empty slots, undefined codes
        send_item(CMD_TICK,     4'd0,  '0, 1'b0, 1'b0, '0);
        send_item(CMD_START,    4'd0,  '0, 1'b0, 1'b0, '0);
        send_item(CMD_PAUSE,    4'd15, '0, 1'b1, 1'b1, '1);
        send_item(CMD_RESTART,  4'd7,  '1, 1'b0, 1'b1, '0);
        send_item(CMD_REMOVE,   4'd0,  '0, 1'b1, 1'b0, '1);
        send_item(CMD_UNDEF_LO, 4'd9,  '1, 1'b1, 1'b1, '1);
        send_item(CMD_UNDEF_HI, 4'd15, 32'h5A5A_A5A5, 1'b0, 1'b1, 32'hA5A5_5A5A);

        // zero period one-shot fires on a zero-length tick and is freed
        send_item(CMD_CREATE,   4'd0,  '0, 1'b1, 1'b0, '0);
        send_item(CMD_TICK,     4'd0,  '0, 1'b0, 1'b0, '0);

        // maximum period, a paused periodic slot and a short one-shot
        send_item(CMD_CREATE,   4'd0,  '1,    1'b1, 1'b1, '0);
        send_item(CMD_CREATE,   4'd0,  32'd5, 1'b0, 1'b1, '0);
        send_item(CMD_CREATE,   4'd0,  32'd3, 1'b1, 1'b0, '0);
        send_item(CMD_TICK,     4'd0,  '0,    1'b0, 1'b0, '1);

        // paused slot keeps its count, restart clears it
        send_item(CMD_START,    4'd1,  '0, 1'b0, 1'b0, '0);
        send_item(CMD_TICK,     4'd0,  '0, 1'b0, 1'b0, 32'd2);
        send_item(CMD_PAUSE,    4'd1,  '0, 1'b0, 1'b0, '0);
        send_item(CMD_TICK,     4'd0,  '0, 1'b0, 1'b0, 32'd10);
        send_item(CMD_RESTART,  4'd1,  '0, 1'b0, 1'b0, '0);
        send_item(CMD_TICK,     4'd0,  '0, 1'b0, 1'b0, 32'd5);
        send_item(CMD_REMOVE,   4'd1,  '0, 1'b0, 1'b0, '0);
        send_item(CMD_REMOVE,   4'd1,  '0, 1'b0, 1'b0, '0);

        // elapsed count overflows and saturates
        send_item(CMD_CREATE,   4'd0,  32'hFFFF_FFFE, 1'b1, 1'b1, '0);
        send_item(CMD_TICK,     4'd0,  '0, 1'b0, 1'b0, '1);

        // fill the bank until creates report full
        send_random_phase(40, 85, 5);

        // long receiver hold-off while items keep coming
        hold_request = 1'b1;
        steady       = 1'b1;
        send_random_phase(20, 30, 40);
        steady       = 1'b0;
        send_random_phase(100, 30, 40);

        // sender waits until every result is in
        wait_drained();
        repeat ($urandom_range(1, 20)) @(negedge clk);

        send_random_phase(100, 20, 50);
        send_random_phase(140, 40, 30);

        wait_drained();
        repeat (2 * NUM_SLOTS + 8) @(negedge clk);

        $display("Covered %0d commands (%0d ticks, %0d creates) over %0d slots",
                 items_sent, ticks_sent, creates_sent, NUM_SLOTS);
        $display("Checked %0d results, %0d of them fire events; %0d failures",
                 results_seen, fires_seen, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/stb_pkg.sv
hdl/stb_if.sv
hdl/stb_ram.sv
hdl/stb_tick_alu.sv
hdl/software_timer_bank.sv
sim/stb_checker.sv
sim/software_timer_bank_tb.sv
